@@ rtl/core/tpff_pkg.sv @@
package tpff_pkg;

  localparam int unsigned KI_W = 16;

  localparam logic [4:0] NAL_IDR = 5'd5;

  localparam logic [1:0] ACT_DROP   = 2'd0;
  localparam logic [1:0] ACT_KEEP   = 2'd1;
  localparam logic [1:0] ACT_REPEAT = 2'd2;

  localparam logic [3:0] RSN_NO_PRIMARY  = 4'd0;
  localparam logic [3:0] RSN_NON_REF     = 4'd1;
  localparam logic [3:0] RSN_IDR_AFTER   = 4'd2;
  localparam logic [3:0] RSN_FIRST_IDR   = 4'd3;
  localparam logic [3:0] RSN_TOO_SOON    = 4'd4;
  localparam logic [3:0] RSN_IDR         = 4'd5;
  localparam logic [3:0] RSN_I_FRAME     = 4'd6;
  localparam logic [3:0] RSN_P_OK        = 4'd7;
  localparam logic [3:0] RSN_REF_SKIPPED = 4'd8;

  localparam logic REG_KEEP_INTERVAL = 1'b0;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/core/tpff_ctrl.sv @@
module tpff_ctrl #(
  parameter int unsigned TOTAL_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tpff_pkg::sts_t sts,
  output tpff_pkg::cmd_t cmd
);

  localparam int unsigned CNT_W = $clog2(TOTAL_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_W'(TOTAL_WIDTH - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts.need_div) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
          if (cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/tpff_dpath.sv @@
module tpff_dpath #(
  parameter int unsigned TOTAL_WIDTH    = 32,
  parameter int unsigned INTERVAL_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tpff_pkg::cmd_t            cmd,
  output tpff_pkg::sts_t            sts,
  input  logic [tpff_pkg::KI_W-1:0] keep_interval,
  input  logic                      has_primary,
  input  logic [1:0]                ref_idc,
  input  logic [4:0]                nal_type,
  input  logic                      slices_all_i,
  input  logic                      slices_all_i_or_p,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_action,
  output logic [3:0]                out_reason
);

  localparam int unsigned KW = tpff_pkg::KI_W;
  localparam int unsigned CW = (INTERVAL_WIDTH > KW) ? INTERVAL_WIDTH : KW;

  logic [INTERVAL_WIDTH-1:0] since_r, since_nxt, since_inc;
  logic [TOTAL_WIDTH-1:0]    seen_r, seen_nxt, seen_inc;
  logic [TOTAL_WIDTH-1:0]    written_r, written_nxt, written_inc;
  logic                      ref_skip_r, ref_skip_nxt;
  logic                      not_idr_r, not_idr_nxt;
  logic                      have_kept_r, have_kept_nxt;
  logic                      no_idr_r, no_idr_nxt;
  logic                      need_div_r, need_div_nxt;
  logic [1:0]                act_r, act_nxt;
  logic [3:0]                rsn_r, rsn_nxt;
  logic [KW-1:0]             rem_r, rem_nxt;
  logic [TOTAL_WIDTH-1:0]    quo_r, quo_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_action_r, out_action_nxt;
  logic [3:0]                out_reason_r, out_reason_nxt;

  logic          is_idr, keep, too_soon, repeat_ok;
  logic [3:0]    rsn_dec;
  logic [KW:0]   trial;

  assign since_inc   = (&since_r) ? since_r : since_r + INTERVAL_WIDTH'(1);
  assign seen_inc    = (&seen_r) ? seen_r : seen_r + TOTAL_WIDTH'(1);
  assign written_inc = (&written_r) ? written_r : written_r + TOTAL_WIDTH'(1);
  assign is_idr      = (nal_type == tpff_pkg::NAL_IDR);
  assign too_soon    = (CW'(since_inc) < CW'(keep_interval));
  assign trial       = {rem_r, quo_r[TOTAL_WIDTH-1]} - {1'b0, keep_interval};
  assign repeat_ok   = need_div_r && (quo_r > written_r);

  always_comb begin
    keep    = 1'b0;
    rsn_dec = tpff_pkg::RSN_REF_SKIPPED;
    priority if (!has_primary) begin
      rsn_dec = tpff_pkg::RSN_NO_PRIMARY;
    end else if (ref_idc == 2'd0) begin
      rsn_dec = tpff_pkg::RSN_NON_REF;
    end else if (is_idr && not_idr_r) begin
      rsn_dec = tpff_pkg::RSN_IDR_AFTER;
      keep    = 1'b1;
    end else if (is_idr && no_idr_r) begin
      rsn_dec = tpff_pkg::RSN_FIRST_IDR;
      keep    = 1'b1;
    end else if (too_soon) begin
      rsn_dec = tpff_pkg::RSN_TOO_SOON;
    end else if (is_idr) begin
      rsn_dec = tpff_pkg::RSN_IDR;
      keep    = 1'b1;
    end else if (slices_all_i) begin
      rsn_dec = tpff_pkg::RSN_I_FRAME;
      keep    = 1'b1;
    end else if (!ref_skip_r && slices_all_i_or_p) begin
      rsn_dec = tpff_pkg::RSN_P_OK;
      keep    = 1'b1;
    end else begin
      rsn_dec = tpff_pkg::RSN_REF_SKIPPED;
    end
  end

  always_comb begin
    since_nxt      = since_r;
    seen_nxt       = seen_r;
    written_nxt    = written_r;
    ref_skip_nxt   = ref_skip_r;
    not_idr_nxt    = not_idr_r;
    have_kept_nxt  = have_kept_r;
    no_idr_nxt     = no_idr_r;
    need_div_nxt   = need_div_r;
    act_nxt        = act_r;
    rsn_nxt        = rsn_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_action_nxt = out_action_r;
    out_reason_nxt = out_reason_r;

    if (cmd.load) begin
      seen_nxt = seen_inc;
      rsn_nxt  = rsn_dec;
      rem_nxt  = '0;
      quo_nxt  = seen_inc;
      if (keep) begin
        since_nxt     = '0;
        written_nxt   = written_inc;
        have_kept_nxt = 1'b1;
        act_nxt       = tpff_pkg::ACT_KEEP;
        need_div_nxt  = 1'b0;
      end else begin
        since_nxt    = since_inc;
        act_nxt      = tpff_pkg::ACT_DROP;
        need_div_nxt = (keep_interval != '0) && have_kept_r;
      end
      if (rsn_dec == tpff_pkg::RSN_IDR_AFTER || rsn_dec == tpff_pkg::RSN_FIRST_IDR) begin
        no_idr_nxt   = 1'b0;
        ref_skip_nxt = 1'b0;
        not_idr_nxt  = 1'b0;
      end else if (rsn_dec == tpff_pkg::RSN_IDR) begin
        ref_skip_nxt = 1'b0;
        not_idr_nxt  = 1'b0;
      end else if (rsn_dec == tpff_pkg::RSN_I_FRAME || rsn_dec == tpff_pkg::RSN_P_OK) begin
        not_idr_nxt = 1'b1;
      end else if (rsn_dec == tpff_pkg::RSN_TOO_SOON ||
                   rsn_dec == tpff_pkg::RSN_REF_SKIPPED) begin
        ref_skip_nxt = 1'b1;
      end
    end

    if (cmd.step) begin
      if (!trial[KW]) begin
        rem_nxt = trial[KW-1:0];
        quo_nxt = {quo_r[TOTAL_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[KW-2:0], quo_r[TOTAL_WIDTH-1]};
        quo_nxt = {quo_r[TOTAL_WIDTH-2:0], 1'b0};
      end
    end

    if (cmd.finish) begin
      out_valid_nxt  = 1'b1;
      out_reason_nxt = rsn_r;
      if (repeat_ok) begin
        out_action_nxt = tpff_pkg::ACT_REPEAT;
        written_nxt    = written_inc;
      end else begin
        out_action_nxt = act_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r     <= '0;
      seen_r      <= '0;
      written_r   <= '0;
      ref_skip_r  <= 1'b0;
      not_idr_r   <= 1'b1;
      have_kept_r <= 1'b0;
      no_idr_r    <= 1'b1;
      need_div_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      since_r     <= since_nxt;
      seen_r      <= seen_nxt;
      written_r   <= written_nxt;
      ref_skip_r  <= ref_skip_nxt;
      not_idr_r   <= not_idr_nxt;
      have_kept_r <= have_kept_nxt;
      no_idr_r    <= no_idr_nxt;
      need_div_r  <= need_div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    rsn_r        <= rsn_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    out_action_r <= out_action_nxt;
    out_reason_r <= out_reason_nxt;
  end

  assign sts.need_div = need_div_r;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_action   = out_action_r;
  assign out_reason   = out_reason_r;

endmodule

@@ rtl/core/h264_trick_play_frame_filter.sv @@
// Flow: an input transfer loads the item; a bit-serial division of the seen count by
//   keep_interval then checks for a repeat, skipped when none is needed (keep, zero
//   interval, nothing kept yet); the result goes to out_valid once no held result is
//   pending. A new item is taken only after the last one's result has been loaded.
// Reset: synchronous on rst_n low; counters clear, keep_interval clears,
//   no result pending.
module h264_trick_play_frame_filter #(
  parameter int unsigned TOTAL_WIDTH    = 32,
  parameter int unsigned INTERVAL_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_has_primary,
  input  logic [1:0]  in_ref_idc,
  input  logic [4:0]  in_nal_type,
  input  logic        in_slices_all_i,
  input  logic        in_slices_all_i_or_p,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_action,
  output logic [3:0]  out_reason
);

  localparam int unsigned KW = tpff_pkg::KI_W;

  logic [KW-1:0]  keep_interval_r, keep_interval_nxt;
  logic           cfg_wr, cfg_sel;
  tpff_pkg::cmd_t cmd;
  tpff_pkg::sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = (cfg_paddr[2] == tpff_pkg::REG_KEEP_INTERVAL);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel;
  assign cfg_prdata = cfg_sel ? 32'(keep_interval_r) : '0;

  always_comb begin
    keep_interval_nxt = keep_interval_r;
    if (cfg_wr) begin
      keep_interval_nxt = cfg_pwdata[KW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_interval_r <= '0;
    end else begin
      keep_interval_r <= keep_interval_nxt;
    end
  end

  tpff_ctrl #(
    .TOTAL_WIDTH(TOTAL_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tpff_dpath #(
    .TOTAL_WIDTH   (TOTAL_WIDTH),
    .INTERVAL_WIDTH(INTERVAL_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .keep_interval    (keep_interval_r),
    .has_primary      (in_has_primary),
    .ref_idc          (in_ref_idc),
    .nal_type         (in_nal_type),
    .slices_all_i     (in_slices_all_i),
    .slices_all_i_or_p(in_slices_all_i_or_p),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_reason       (out_reason)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("more than one datapath command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid && !out_ready))
    else $error("result loaded over a pending transfer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

  a_keep_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == tpff_pkg::ACT_KEEP) |->
      (out_reason == tpff_pkg::RSN_IDR_AFTER || out_reason == tpff_pkg::RSN_FIRST_IDR ||
       out_reason == tpff_pkg::RSN_IDR || out_reason == tpff_pkg::RSN_I_FRAME ||
       out_reason == tpff_pkg::RSN_P_OK))
    else $error("keep with a drop reason");

endmodule

@@ verif/tb_h264_trick_play_frame_filter.sv @@
`timescale 1ns / 100ps

module tb_h264_trick_play_frame_filter;

  localparam logic [2:0] KI_ADDR = {tpff_pkg::REG_KEEP_INTERVAL, 2'b00};
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_CYCLES = 400;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic       has_primary;
    logic [1:0] ref_idc;
    logic [4:0] nal_type;
    logic       all_i;
    logic       all_ip;
  } frame_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] reason;
  } decision_t;

  typedef enum {
    K_IDR, K_I, K_P, K_BREF, K_BNONREF, K_NOPRIM, K_NOISE
  } frame_kind_t;

  class decision_scoreboard;
    logic [15:0] interval;
    logic [15:0] since_kept;
    logic [31:0] seen;
    logic [31:0] written;
    logic        ref_skipped;
    logic        last_not_idr;
    logic        have_kept;
    logic        no_idr_yet;
    decision_t   decisions_due[$];
    int          mismatches;

    function new();
      interval     = '0;
      since_kept   = '0;
      seen         = '0;
      written      = '0;
      ref_skipped  = 1'b0;
      last_not_idr = 1'b1;
      have_kept    = 1'b0;
      no_idr_yet   = 1'b1;
      mismatches   = 0;
    endfunction

    function void set_interval(logic [15:0] v);
      interval = v;
    endfunction

    function decision_t predict_decision(frame_t f);
      decision_t   d;
      logic        keep;
      logic        idr;
      logic [31:0] wanted;
      idr = (f.nal_type == tpff_pkg::NAL_IDR);
      keep = 1'b0;
      d.action = tpff_pkg::ACT_DROP;
      if (since_kept != '1) since_kept = since_kept + 16'd1;
      if (seen != '1) seen = seen + 32'd1;
      if (!f.has_primary) begin
        d.reason = tpff_pkg::RSN_NO_PRIMARY;
      end else if (f.ref_idc == 2'd0) begin
        d.reason = tpff_pkg::RSN_NON_REF;
      end else if (idr && last_not_idr) begin
        d.reason = tpff_pkg::RSN_IDR_AFTER;
        keep = 1'b1;
        no_idr_yet = 1'b0;
        ref_skipped = 1'b0;
        last_not_idr = 1'b0;
      end else if (idr && no_idr_yet) begin
        d.reason = tpff_pkg::RSN_FIRST_IDR;
        keep = 1'b1;
        no_idr_yet = 1'b0;
        ref_skipped = 1'b0;
        last_not_idr = 1'b0;
      end else if (since_kept < interval) begin
        d.reason = tpff_pkg::RSN_TOO_SOON;
        ref_skipped = 1'b1;
      end else if (idr) begin
        d.reason = tpff_pkg::RSN_IDR;
        keep = 1'b1;
        ref_skipped = 1'b0;
        last_not_idr = 1'b0;
      end else if (f.all_i) begin
        d.reason = tpff_pkg::RSN_I_FRAME;
        keep = 1'b1;
        last_not_idr = 1'b1;
      end else if (!ref_skipped && f.all_ip) begin
        d.reason = tpff_pkg::RSN_P_OK;
        keep = 1'b1;
        last_not_idr = 1'b1;
      end else begin
        d.reason = tpff_pkg::RSN_REF_SKIPPED;
        ref_skipped = 1'b1;
      end
      if (keep) begin
        d.action = tpff_pkg::ACT_KEEP;
        have_kept = 1'b1;
        if (written != '1) written = written + 32'd1;
        since_kept = '0;
      end else if (interval != '0) begin
        wanted = seen / {16'd0, interval};
        if (wanted > written && have_kept) begin
          d.action = tpff_pkg::ACT_REPEAT;
          if (written != '1) written = written + 32'd1;
        end
      end
      return d;
    endfunction

    function void note_frame(frame_t f);
      decisions_due.push_back(predict_decision(f));
    endfunction

    function int pending();
      return decisions_due.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_decision(logic [1:0] action, logic [3:0] reason);
      decision_t e;
      if (decisions_due.size() == 0) begin
        report($sformatf("unexpected result action=%0d reason=%0d", action, reason));
        return;
      end
      e = decisions_due.pop_front();
      if (action !== e.action)
        report($sformatf("action got %0d want %0d", action, e.action));
      if (reason !== e.reason)
        report($sformatf("reason got %0d want %0d", reason, e.reason));
    endtask

    task check_drained();
      if (decisions_due.size() != 0)
        report($sformatf("%0d results never arrived", decisions_due.size()));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid;
  logic        in_ready;
  logic        in_has_primary;
  logic [1:0]  in_ref_idc;
  logic [4:0]  in_nal_type;
  logic        in_slices_all_i;
  logic        in_slices_all_i_or_p;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_action;
  logic [3:0]  out_reason;

  decision_scoreboard sb;
  bit src_burst;
  bit snk_burst;
  bit stall_sink_req;

  h264_trick_play_frame_filter dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_has_primary       (in_has_primary),
    .in_ref_idc           (in_ref_idc),
    .in_nal_type          (in_nal_type),
    .in_slices_all_i      (in_slices_all_i),
    .in_slices_all_i_or_p (in_slices_all_i_or_p),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_action           (out_action),
    .out_reason           (out_reason)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** h264_trick_play_frame_filter: FAILED **");
    $finish;
  end

  function automatic frame_t mk(logic h, logic [1:0] r, logic [4:0] n, logic i, logic p);
    frame_t f;
    f.has_primary = h;
    f.ref_idc = r;
    f.nal_type = n;
    f.all_i = i;
    f.all_ip = p;
    return f;
  endfunction

  function automatic frame_t make_frame(frame_kind_t k);
    frame_t f;
    f = mk(1'b1, 2'($urandom_range(1, 3)), NAL_SLICE, 1'b0, 1'b1);
    unique case (k)
      K_IDR: begin
        f.nal_type = tpff_pkg::NAL_IDR;
        f.all_i = ($urandom_range(0, 9) != 0);
      end
      K_I: f.all_i = 1'b1;
      K_P: ;
      K_BREF: f.all_ip = 1'b0;
      K_BNONREF: begin
        f.ref_idc = 2'd0;
        f.all_ip = $urandom_range(0, 3) == 0;
      end
      K_NOPRIM: begin
        f = frame_t'(10'($urandom_range(0, 1023)));
        f.has_primary = 1'b0;
      end
      default: f = frame_t'(10'($urandom_range(0, 1023)));
    endcase
    return f;
  endfunction

  function automatic int src_gap();
    return src_burst ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send_frame(frame_t f, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_has_primary <= f.has_primary;
    in_ref_idc <= f.ref_idc;
    in_nal_type <= f.nal_type;
    in_slices_all_i <= f.all_i;
    in_slices_all_i_or_p <= f.all_ip;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_frame(f);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= KI_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic program_interval(logic [15:0] v);
    logic [31:0] rd;
    idle_input();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_access(1'b1, {16'd0, v}, rd);
    sb.set_interval(v);
    @(posedge clk);
    cfg_access(1'b0, 32'd0, rd);
    if (rd[15:0] !== v)
      sb.report($sformatf("keep_interval readback %0h want %0h", rd[15:0], v));
  endtask

  task automatic run_phase(int count, bit hold_sink, bit pause_mid);
    int pos;
    int gop_len;
    int r;
    frame_kind_t k;
    pos = 0;
    gop_len = $urandom_range(4, 20);
    for (int n = 0; n < count; n++) begin
      if (hold_sink && n == 5) stall_sink_req = 1'b1;
      if (pause_mid && n == count / 2) begin
        idle_input();
        wait_drain();
      end
      if (n % 40 == 0) src_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (pos == 0) k = (r < 70) ? K_IDR : K_I;
      else if (r < 10) k = K_NOISE;
      else if (r < 15) k = K_NOPRIM;
      else if (r < 50) k = K_P;
      else if (r < 80) k = K_BNONREF;
      else if (r < 88) k = K_BREF;
      else if (r < 94) k = K_I;
      else k = K_IDR;
      send_frame(make_frame(k), src_gap());
      pos++;
      if (pos == gop_len) begin
        pos = 0;
        gop_len = $urandom_range(4, 20);
      end
    end
  endtask

  initial begin
    int gap;
    out_ready = 1'b0;
    snk_burst = 1'b0;
    wait (rst_n);
    for (int n = 0; ; n++) begin
      if (n % 40 == 0) snk_burst = ($urandom_range(0, 3) == 0);
      gap = snk_burst ? 0 : $urandom_range(0, 15);
      if (stall_sink_req) begin
        stall_sink_req = 1'b0;
        gap = STALL_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_decision(out_action, out_reason);
    end
  end

  initial begin
    logic [15:0] intervals [10];
    sb = new();
    src_burst = 1'b0;
    stall_sink_req = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_valid = 1'b0;
    in_has_primary = 1'b0;
    in_ref_idc = '0;
    in_nal_type = '0;
    in_slices_all_i = 1'b0;
    in_slices_all_i_or_p = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_interval(16'd1);
    send_frame(mk(1'b0, 2'd3, tpff_pkg::NAL_IDR, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd0, NAL_SLICE, 1'b0, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd1, NAL_SLICE, 1'b0, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd0, NAL_SLICE, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd3, tpff_pkg::NAL_IDR, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd2, tpff_pkg::NAL_IDR, 1'b0, 1'b0), src_gap());
    send_frame(mk(1'b1, 2'd1, NAL_SLICE, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd2, NAL_SLICE, 1'b0, 1'b0), src_gap());
    send_frame(mk(1'b1, 2'd1, NAL_SLICE, 1'b0, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd3, NAL_SLICE, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd1, tpff_pkg::NAL_IDR, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd1, NAL_SLICE, 1'b0, 1'b1), src_gap());

    program_interval(16'd3);
    send_frame(mk(1'b1, 2'd2, NAL_SLICE, 1'b0, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd2, tpff_pkg::NAL_IDR, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd1, NAL_SLICE, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd3, 5'd31, 1'b1, 1'b0), src_gap());
    send_frame(mk(1'b1, 2'd3, 5'd31, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd1, 5'd0, 1'b0, 1'b0), src_gap());

    program_interval(16'd0);
    send_frame(mk(1'b1, 2'd1, NAL_SLICE, 1'b0, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd1, NAL_SLICE, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd1, tpff_pkg::NAL_IDR, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b0, 2'd0, 5'd0, 1'b0, 1'b0), src_gap());

    program_interval(16'hFFFF);
    send_frame(mk(1'b1, 2'd3, tpff_pkg::NAL_IDR, 1'b1, 1'b1), src_gap());
    send_frame(mk(1'b1, 2'd3, NAL_SLICE, 1'b1, 1'b1), src_gap());

    intervals[0] = 16'd1;
    intervals[1] = 16'd0;
    intervals[2] = 16'd2;
    intervals[3] = 16'd3;
    intervals[4] = 16'hFFFF;
    intervals[5] = 16'd5;
    intervals[6] = 16'($urandom_range(1, 8));
    intervals[7] = 16'd4;
    intervals[8] = 16'($urandom_range(0, 65535));
    intervals[9] = 16'($urandom_range(1, 16));
    for (int p = 0; p < 10; p++) begin
      program_interval(intervals[p]);
      run_phase(PHASE_ITEMS, (p == 2) || (p == 7), (p == 4) || (p == 8));
    end

    idle_input();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("** h264_trick_play_frame_filter: PASSED **");
    end else begin
      $display("** h264_trick_play_frame_filter: FAILED **");
    end
    $finish;
  end

endmodule
